### rtl/core/ftsr_pkg.sv
// Shared constants for the flat triangle span rasterizer.
// No dependencies; used by the core and its port checker.
package ftsr_pkg;

    localparam int CW = 12;   // config and span field width
    localparam int VW = 16;   // vertex coordinate width
    localparam int RW = 17;   // row register width (signed)
    localparam int PW = 32;   // pixel word and fixed-point width

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CW-1:0] WIDTH_RESET  = 12'd960;
    localparam logic [CW-1:0] HEIGHT_RESET = 12'd300;

endpackage

### rtl/core/flat_triangle_span_rasterizer.sv
// Top level of the flat triangle span rasterizer.
// Depends on ftsr_pkg and ftsr_div.
//
// A load transfer (func=0) sorts the vertices by row, culls triangles lying
// wholly above or below the screen, sets up three fixed-point edge slopes
// with one shared iterative divider and skips rows above row 0 with one
// shared multiplier. A step transfer (func=1) emits the span of the current
// row and advances one row. Every input transfer yields exactly one result
// transfer. A step updates the edges when accepted, then does the row/half
// bookkeeping; a load runs three slope divisions back to back on the
// bit-serial divider. o_stall is high while an item is in work;
// the result register lets a new item enter while the previous result waits.
module flat_triangle_span_rasterizer #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_addr,
    input  logic [11:0]          i_cfg_wr_data,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  logic signed [15:0]   i_vertex_a_x,
    input  logic signed [15:0]   i_vertex_a_y,
    input  logic signed [15:0]   i_vertex_b_x,
    input  logic signed [15:0]   i_vertex_b_y,
    input  logic signed [15:0]   i_vertex_c_x,
    input  logic signed [15:0]   i_vertex_c_y,
    input  logic [31:0]          i_fill_colour,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_span_valid,
    output logic [11:0]          o_span_row,
    output logic [11:0]          o_span_start,
    output logic [11:0]          o_span_length,
    output logic [31:0]          o_span_colour,
    output logic                 o_done_res
);

    localparam int CW  = ftsr_pkg::CW;
    localparam int RW  = ftsr_pkg::RW;
    localparam int PW  = ftsr_pkg::PW;
    localparam int NW  = RW + FRAC_BITS;   // |dx| << FRAC_BITS
    localparam int SW  = PW - FRAC_BITS;   // integer part of a fixed value
    localparam int DRW = RW + 1;           // row difference

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;

    // config registers
    logic [CW-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ftsr_pkg::WIDTH_RESET;
            r_height <= ftsr_pkg::HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                ftsr_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_wr_data;
                ftsr_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // control
    logic [2:0] r_state, n_state;
    logic [2:0] r_k;
    logic       r_start;
    logic       r_cull;
    logic       accept;

    // triangle state
    logic signed [RW-1:0] r_x1, r_x2, r_x3, r_y1, r_y2, r_y3;
    logic signed [PW-1:0] r_q1, r_q2, r_q3;
    logic [PW-1:0]        r_left, r_span_w, r_lslope, r_wslope, r_llslope, r_lwslope;
    logic signed [RW-1:0] r_cur, r_half, r_bottom;
    logic                 r_lower, r_active;
    logic [31:0]          r_colour;
    logic [PW-1:0]        r_prod;

    // pending result fields
    logic          r_pv;
    logic [CW-1:0] r_prow, r_pstart, r_plen;
    logic [31:0]   r_pcol;

    // result register
    logic          r_out_valid;
    logic          slot_free;

    assign o_stall   = (r_state != S_IDLE) || !i_rst_n;
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;

    // ---- sort and cull, straight off the input ----
    logic signed [RW-1:0] sx1, sy1, sx2, sy2, sx3, sy3, tx, ty;
    logic                 culled;
    logic signed [RW-1:0] ny1, ny3;

    always_comb begin
        tx = '0;
        ty = '0;
        sx1 = RW'(i_vertex_a_x); sy1 = RW'(i_vertex_a_y);
        sx2 = RW'(i_vertex_b_x); sy2 = RW'(i_vertex_b_y);
        sx3 = RW'(i_vertex_c_x); sy3 = RW'(i_vertex_c_y);
        if (sy2 < sy1) begin
            tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
        end
        if (sy3 < sy1) begin
            tx = sx1; ty = sy1; sx1 = sx3; sy1 = sy3; sx3 = tx; sy3 = ty;
        end
        if (sy3 < sy2) begin
            tx = sx2; ty = sy2; sx2 = sx3; sy2 = sy3; sx3 = tx; sy3 = ty;
        end
        culled = (sy3 < 0) || (sy1 > $signed({1'b0, r_height}));
        // nudge flat edges apart
        ny1 = (sy1 == sy2) ? sy1 - 1'b1 : sy1;
        ny3 = (sy3 == sy2) ? sy3 + 1'b1 : sy3;
    end

    // ---- shared divider ----
    logic signed [RW-1:0] dx;
    logic signed [DRW-1:0] dy;
    logic [RW-1:0]        dx_mag;
    logic [NW-1:0]        div_num;
    logic                 div_done;
    logic [NW-1:0]        div_quot;
    logic signed [PW-1:0] q_signed;

    always_comb begin
        unique case (r_k[1:0])
            2'd0:    begin dx = r_x3 - r_x1; dy = DRW'(r_y3) - DRW'(r_y1); end
            2'd1:    begin dx = r_x2 - r_x1; dy = DRW'(r_y2) - DRW'(r_y1); end
            default: begin dx = r_x3 - r_x2; dy = DRW'(r_y3) - DRW'(r_y2); end
        endcase
        dx_mag  = dx[RW-1] ? RW'(-dx) : RW'(dx);
        div_num = NW'(dx_mag) << FRAC_BITS;
    end

    ftsr_div #(.NW(NW), .DW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (div_num),
        .i_den   (dy[RW-1:0]),    // always positive after the nudge
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // truncating division: negate magnitude quotient when dx < 0
    assign q_signed = dx[RW-1] ? -$signed(PW'(div_quot)) : $signed(PW'(div_quot));

    // ---- shared multiplier: low 32 bits of row count times slope ----
    logic signed [DRW-1:0]      mul_a;
    logic signed [PW-1:0]       mul_b;
    logic signed [DRW+PW-1:0]   mul_p;
    logic signed [DRW-1:0]      d_top;

    assign d_top = DRW'(r_y2) - DRW'(r_y1);

    always_comb begin
        mul_a = '0;
        mul_b = $signed(r_lslope);
        unique case (r_k)
            3'd0:    begin mul_a = (r_y2 < 0) ? d_top : '0; mul_b = $signed(r_lslope); end
            3'd1:    begin mul_a = (r_y2 < 0) ? d_top : '0; mul_b = $signed(r_wslope); end
            3'd3:    begin mul_a = (r_cur < 0) ? DRW'(r_cur) : '0; mul_b = $signed(r_lslope); end
            3'd4:    begin mul_a = (r_cur < 0) ? DRW'(r_cur) : '0; mul_b = $signed(r_wslope); end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // ---- step span math ----
    logic [PW-1:0]        edge_sum;
    logic signed [SW-1:0] j0, jl0, jc, jlc, w_ext;
    logic                 sp_valid;

    always_comb begin
        edge_sum = r_span_w + r_left;
        j0       = SW'($signed(r_left) >>> FRAC_BITS);
        jl0      = SW'($signed(edge_sum) >>> FRAC_BITS);
        w_ext    = $signed(SW'(r_width));
        jc       = (j0 < 0) ? '0 : j0;
        jlc      = (jl0 > w_ext) ? w_ext : jl0;
        sp_valid = jc < jlc;
    end

    // ---- next row ready: switch to the lower half when the upper is spent ----
    logic signed [RW:0]   h_ext;
    logic                 up_ok, sw_half, row_ready;
    logic signed [RW-1:0] half_n;

    always_comb begin
        h_ext     = $signed({6'b0, r_height});
        up_ok     = (r_cur < r_half) && ((RW + 1)'(r_cur) < h_ext);
        sw_half   = !r_lower && !up_ok;
        half_n    = sw_half ? r_bottom : r_half;
        row_ready = (r_cur < half_n) && ((RW + 1)'(r_cur) < h_ext);
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == ftsr_pkg::FUNC_LOAD && !culled) n_state = S_DIV;
                    else                                          n_state = S_EVAL;
                end
            end
            S_DIV:  if (div_done && r_k == 3'd2) n_state = S_SEL;
            S_SEL:  n_state = S_MUL;
            S_MUL:  if (r_k == 3'd5) n_state = S_EVAL;
            S_EVAL: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_start  <= 1'b0;
            r_cull   <= 1'b0;
            r_active <= 1'b0;
            r_lower  <= 1'b0;
            r_cur    <= '0;
            r_half   <= '0;
            r_bottom <= '0;
            r_left   <= '0;
            r_span_w <= '0;
            r_lslope <= '0;
            r_wslope <= '0;
            r_llslope <= '0;
            r_lwslope <= '0;
            r_colour <= '0;
        end else begin
            r_state <= n_state;
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_func == ftsr_pkg::FUNC_LOAD) begin
                            r_colour <= i_fill_colour;
                            r_active <= 1'b0;
                            r_cull   <= culled;
                            r_k      <= '0;
                            r_start  <= !culled;
                        end else if (!r_active) begin
                            r_cull <= 1'b1;
                        end else begin
                            r_cull   <= 1'b0;
                            r_left   <= r_left + r_lslope;
                            r_span_w <= r_span_w + r_wslope;
                            r_cur    <= r_cur + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        unique case (r_k[1:0])
                            2'd0:    r_q1 <= q_signed;
                            2'd1:    r_q2 <= q_signed;
                            default: r_q3 <= q_signed;
                        endcase
                        if (r_k != 3'd2) begin
                            r_k     <= r_k + 1'b1;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_SEL: begin
                    if (r_q1 <= r_q2) begin
                        r_wslope  <= PW'(r_q2 - r_q1) | PW'(1);
                        r_lwslope <= PW'(r_q3 - r_q1);
                        r_lslope  <= PW'(r_q1);
                        r_llslope <= PW'(r_q1);
                    end else begin
                        r_wslope  <= PW'(r_q1 - r_q2) | PW'(1);
                        r_lwslope <= PW'(r_q1 - r_q3);
                        r_lslope  <= PW'(r_q2);
                        r_llslope <= PW'(r_q3);
                    end
                    r_left   <= PW'(PW'(r_x1) << FRAC_BITS);
                    r_span_w <= PW'(1) << FRAC_BITS;
                    r_cur    <= r_y1;
                    r_half   <= r_y2;
                    r_bottom <= r_y3;
                    r_lower  <= 1'b0;
                    r_k      <= '0;
                end
                S_MUL: begin
                    r_k <= r_k + 1'b1;
                    unique case (r_k)
                        3'd1: r_left   <= r_left + r_prod;
                        3'd2: begin
                            r_span_w <= r_span_w + r_prod;
                            if (r_y2 < 0) begin
                                // upper half lies above the screen
                                r_cur    <= r_y2;
                                r_half   <= r_y3;
                                r_lslope <= r_llslope;
                                r_wslope <= r_lwslope;
                                r_lower  <= 1'b1;
                            end
                        end
                        3'd4: r_left   <= r_left - r_prod;
                        3'd5: begin
                            r_span_w <= r_span_w - r_prod;
                            if (r_cur < 0) r_cur <= '0;
                        end
                        default: ;
                    endcase
                end
                S_EVAL: begin
                    if (!r_cull) begin
                        if (sw_half) begin
                            r_half   <= r_bottom;
                            r_wslope <= r_lwslope;
                            r_lslope <= r_llslope;
                            r_lower  <= 1'b1;
                        end
                        r_active <= row_ready;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload-only registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[PW-1:0];
        if (accept && i_func == ftsr_pkg::FUNC_LOAD) begin
            r_x1 <= sx1; r_x2 <= sx2; r_x3 <= sx3;
            r_y1 <= ny1; r_y2 <= sy2; r_y3 <= ny3;
        end
        if (accept) begin
            r_pv     <= 1'b0;
            r_prow   <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_pcol   <= '0;
            if (i_func == ftsr_pkg::FUNC_STEP && r_active) begin
                r_pv     <= sp_valid;
                r_prow   <= r_cur[CW-1:0];
                r_pcol   <= r_colour;
                r_pstart <= sp_valid ? jc[CW-1:0] : '0;
                r_plen   <= sp_valid ? CW'(jlc - jc) : '0;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EVAL && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL && slot_free) begin
            o_span_valid  <= r_pv;
            o_span_row    <= r_prow;
            o_span_start  <= r_pstart;
            o_span_length <= r_plen;
            o_span_colour <= r_pcol;
            o_done_res    <= r_cull || !row_ready;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### rtl/core/ftsr_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by the rasterizer for the slope setup.
module ftsr_div #(
    parameter int NW = 25,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CNW = $clog2(NW + 1);

    logic [DW:0]    r_rem;
    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DW:0]    rem_sh;
    logic           fit;

    assign rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
    assign fit    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[NW-2:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/core/ftsr_chk.sv
// Port-level checker for the flat triangle span rasterizer, with its bind.
// Depends on ftsr_pkg for field widths.
module ftsr_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic                     o_span_valid,
    input logic [ftsr_pkg::CW-1:0]  o_span_row,
    input logic [ftsr_pkg::CW-1:0]  o_span_start,
    input logic [ftsr_pkg::CW-1:0]  o_span_length
);

    // a stalled result stays valid and keeps its row and length
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_span_row) && $stable(o_span_length))
        else $error("stalled result changed");

    // an accepted item raises o_stall in the cycle after
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted back to back");

    // a filled span is never empty
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_valid |-> o_span_length != '0)
        else $error("valid span of zero length");

    // an empty row reports no start or length
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_span_valid |-> o_span_start == '0 && o_span_length == '0)
        else $error("empty span carries coordinates");

endmodule

bind flat_triangle_span_rasterizer ftsr_chk u_ftsr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_span_valid  (o_span_valid),
    .o_span_row    (o_span_row),
    .o_span_start  (o_span_start),
    .o_span_length (o_span_length)
);
